// ----- src/tlmg_pkg.sv -----
`default_nettype none
package tlmg_pkg;

   localparam int POS_BITS_DEF = 20;
   localparam int AGE_BITS_DEF = 16;
   localparam int VEL_BITS     = 17;
   localparam int SPEED_BITS   = 16;
   localparam int CSR_BITS     = 19;
   localparam int CSR_IDX_BITS = 3;
   localparam int TYPE_BITS    = 3;
   localparam int MODE_BITS    = 2;

   localparam logic [TYPE_BITS-1:0] REQ_CONTROL  = 3'd0;
   localparam logic [TYPE_BITS-1:0] REQ_TAG      = 3'd1;
   localparam logic [TYPE_BITS-1:0] REQ_ALTITUDE = 3'd2;
   localparam logic [TYPE_BITS-1:0] REQ_MODE     = 3'd3;
   localparam logic [TYPE_BITS-1:0] REQ_TICK     = 3'd4;

   localparam logic [MODE_BITS-1:0] MODE_WAITING  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_TRACKING = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_LANDING  = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_SPEED    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTER_TOL   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LANDING_ALT  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HOVER_OFFSET = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRESH_TICKS  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOST_TICKS   = 3'd5;

endpackage
`default_nettype wire

// ----- src/tlmg_engine.sv -----
`default_nettype none
module tlmg_engine #(
   parameter int EW = 21
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   input  wire logic [tlmg_pkg::SPEED_BITS-1:0]        max_speed,
   input  wire logic [2:0][EW-1:0]                     mag_in,
   output logic                                        done,
   output logic [2:0][tlmg_pkg::SPEED_BITS-1:0]        quo_out
);
   import tlmg_pkg::*;

   localparam int SW   = 2 * EW + 2;
   localparam int HW   = SW / 2;
   localparam int RW   = EW + 3;
   localparam int NW   = EW + 18;
   localparam int MCW  = (SW > NW) ? SW : NW;
   localparam int MPW  = (EW > SPEED_BITS) ? EW : SPEED_BITS;
   localparam int CNTW = $clog2(NW + 1);

   typedef enum logic [4:0] {
      E_IDLE = 5'b00001,
      E_SQ   = 5'b00010,
      E_SQRT = 5'b00100,
      E_MUL  = 5'b01000,
      E_DIV  = 5'b10000
   } eng_state_type;

   eng_state_type                 state_ff, state_in;
   logic                          done_ff, done_in;
   logic [1:0]                    idx_ff, idx_in;
   logic [CNTW-1:0]               cnt_ff, cnt_in;
   logic [2:0][EW-1:0]            m_ff, m_in;
   logic [SPEED_BITS-1:0]         ms_ff, ms_in;
   logic [SW-1:0]                 acc_ff, acc_in;
   logic [MCW-1:0]                mcand_ff, mcand_in;
   logic [MPW-1:0]                mplier_ff, mplier_in;
   logic [RW-1:0]                 rem_ff, rem_in;
   logic [EW:0]                   root_ff, root_in;
   logic [NW-1:0]                 num_ff, num_in;
   logic [SPEED_BITS-1:0]         quo_ff, quo_in;
   logic [2:0][SPEED_BITS-1:0]    q_ff, q_in;

   logic [RW-1:0]                 sq_rem, sq_trial, dv_rem, dv_den;

   always_comb begin
      sq_rem   = {rem_ff[RW-3:0], acc_ff[SW-1:SW-2]};
      sq_trial = {root_ff, 2'b01};
      dv_rem   = {rem_ff[RW-2:0], num_ff[NW-1]};
      dv_den   = {1'b0, root_ff, 1'b0};

      state_in  = state_ff;
      done_in   = 1'b0;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      m_in      = m_ff;
      ms_in     = ms_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      num_in    = num_ff;
      quo_in    = quo_ff;
      q_in      = q_ff;

      case (state_ff)
         E_IDLE: begin
            if (start) begin
               m_in      = mag_in;
               ms_in     = max_speed;
               idx_in    = 2'd0;
               acc_in    = '0;
               mcand_in  = MCW'(mag_in[0]);
               mplier_in = MPW'(mag_in[0]);
               cnt_in    = CNTW'(EW - 1);
               state_in  = E_SQ;
            end
         end
         E_SQ: begin
            if (mplier_ff[0]) acc_in = acc_ff + mcand_ff[SW-1:0];
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (idx_ff == 2'd2) begin
                  rem_in   = '0;
                  root_in  = '0;
                  cnt_in   = CNTW'(HW - 1);
                  state_in = E_SQRT;
               end else begin
                  idx_in    = idx_ff + 1'b1;
                  mcand_in  = MCW'(m_ff[idx_ff + 1'b1]);
                  mplier_in = MPW'(m_ff[idx_ff + 1'b1]);
                  cnt_in    = CNTW'(EW - 1);
               end
            end
         end
         E_SQRT: begin
            acc_in = acc_ff << 2;
            if (sq_rem >= sq_trial) begin
               rem_in  = sq_rem - sq_trial;
               root_in = {root_ff[EW-1:0], 1'b1};
            end else begin
               rem_in  = sq_rem;
               root_in = {root_ff[EW-1:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               idx_in    = 2'd0;
               num_in    = '0;
               mcand_in  = MCW'(m_ff[0]);
               mplier_in = MPW'(ms_ff);
               cnt_in    = CNTW'(SPEED_BITS - 1);
               state_in  = E_MUL;
            end
         end
         E_MUL: begin
            if (mplier_ff[0]) num_in = num_ff + mcand_ff[NW-1:0];
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               num_in   = {num_in[NW-2:0], 1'b0} + NW'(root_ff);
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = CNTW'(NW - 1);
               state_in = E_DIV;
            end
         end
         E_DIV: begin
            num_in = num_ff << 1;
            if (dv_rem >= dv_den) begin
               rem_in = dv_rem - dv_den;
               quo_in = {quo_ff[SPEED_BITS-2:0], 1'b1};
            end else begin
               rem_in = dv_rem;
               quo_in = {quo_ff[SPEED_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               q_in[idx_ff] = (root_ff == '0) ? '0 : quo_in;
               if (idx_ff == 2'd2) begin
                  done_in  = 1'b1;
                  state_in = E_IDLE;
               end else begin
                  idx_in    = idx_ff + 1'b1;
                  num_in    = '0;
                  mcand_in  = MCW'(m_ff[idx_ff + 1'b1]);
                  mplier_in = MPW'(ms_ff);
                  cnt_in    = CNTW'(SPEED_BITS - 1);
                  state_in  = E_MUL;
               end
            end
         end
         default: state_in = E_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      idx_ff    <= idx_in;
      cnt_ff    <= cnt_in;
      m_ff      <= m_in;
      ms_ff     <= ms_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      num_ff    <= num_in;
      quo_ff    <= quo_in;
      q_ff      <= q_in;
   end

   assign done    = done_ff;
   assign quo_out = q_ff;

endmodule
`default_nettype wire

// ----- src/tag_landing_mode_guidance_top.sv -----
// Landing guidance mode machine.
// Request channel (req_valid/req_ready) carries one event per beat: control
// step, tag detection, altitude update, mode request or time tick. Only a
// control step in tracking or landing mode produces a response beat on
// rsp_valid/rsp_ready: a velocity command plus the mode used and next mode.
// Non-control events keep the block idle. A landing command is presented in the
// cycle after acceptance. A tracking command runs through one shared
// shift-add / restoring unit: squares of all three axes, a square root,
// then a multiply and a divide per axis, with EW = min(POS_BITS+2, 31) for
// POS_BITS >= 16. req_ready is high only when idle; while a response beat
// waits for rsp_ready, it is held and no new request is taken.
// Reset returns to waiting mode, zero target and altitude, stale tag age and
// the default register values. csr_we writes one register per cycle and
// should only be used while idle.
`default_nettype none
module tag_landing_mode_guidance_top #(
   parameter int POS_BITS = tlmg_pkg::POS_BITS_DEF,
   parameter int AGE_BITS = tlmg_pkg::AGE_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [tlmg_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [tlmg_pkg::CSR_BITS-1:0]        csr_wdata,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [tlmg_pkg::TYPE_BITS-1:0]       req_type,
   input  wire logic signed [POS_BITS-1:0]           req_tag_x,
   input  wire logic signed [POS_BITS-1:0]           req_tag_y,
   input  wire logic signed [POS_BITS-1:0]           req_tag_z,
   input  wire logic signed [POS_BITS-1:0]           req_altitude,
   input  wire logic                                 req_mode_request,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [tlmg_pkg::VEL_BITS-1:0]      rsp_vel_x,
   output logic signed [tlmg_pkg::VEL_BITS-1:0]      rsp_vel_y,
   output logic signed [tlmg_pkg::VEL_BITS-1:0]      rsp_vel_z,
   output logic [tlmg_pkg::MODE_BITS-1:0]            rsp_mode_used,
   output logic [tlmg_pkg::MODE_BITS-1:0]            rsp_mode_next
);
   import tlmg_pkg::*;

   localparam int GW  = ((POS_BITS > 16) ? POS_BITS : 16) + 2;
   localparam int EW  = (GW < 31) ? GW : 31;
   localparam int CW  = ((POS_BITS > CSR_BITS) ? POS_BITS : CSR_BITS) + 1;
   localparam int AW  = (AGE_BITS > SPEED_BITS) ? AGE_BITS : SPEED_BITS;

   typedef enum logic [2:0] {
      T_IDLE = 3'b001,
      T_CALC = 3'b010,
      T_RESP = 3'b100
   } top_state_type;

   top_state_type               state_ff, state_in;
   logic [SPEED_BITS-1:0]       max_speed_ff, center_tol_ff, hover_ff, fresh_ff, lost_ff;
   logic [CSR_BITS-1:0]         land_alt_ff;
   logic [MODE_BITS-1:0]        mode_ff, mode_in;
   logic signed [POS_BITS-1:0]  tgt_x_ff, tgt_y_ff, tgt_z_ff;
   logic signed [POS_BITS-1:0]  alt_ff;
   logic [AGE_BITS-1:0]         age_ff;
   logic [2:0]                  neg_ff, neg_in;
   logic signed [VEL_BITS-1:0]  vx_ff, vy_ff, vz_ff, vx_in, vy_in, vz_in;
   logic [MODE_BITS-1:0]        used_ff, next_ff, used_in, next_in;

   logic                        accept, eng_start, eng_done;
   logic signed [GW-1:0]        gx, gy, gz;
   logic [GW-1:0]               mx, my, mz;
   logic [2:0][EW-1:0]          eng_mag;
   logic [2:0][SPEED_BITS-1:0]  eng_q;
   logic [POS_BITS-1:0]         ax, ay;
   logic                        centred, fresh, lost;

   function automatic logic signed [POS_BITS-1:0] neg_sat(input logic signed [POS_BITS-1:0] v);
      logic signed [POS_BITS-1:0] r;
      if (v == {1'b1, {(POS_BITS-1){1'b0}}}) r = {1'b0, {(POS_BITS-1){1'b1}}};
      else r = -v;
      return r;
   endfunction

   assign accept = req_valid && req_ready;

   always_comb begin
      gx = GW'(tgt_x_ff);
      gy = GW'(tgt_y_ff);
      gz = GW'(tgt_z_ff) + $signed({{(GW-SPEED_BITS){1'b0}}, hover_ff});
      mx = gx[GW-1] ? GW'(-gx) : GW'(gx);
      my = gy[GW-1] ? GW'(-gy) : GW'(gy);
      mz = gz[GW-1] ? GW'(-gz) : GW'(gz);
      if (((mx >> 31) != '0) || ((my >> 31) != '0) || ((mz >> 31) != '0)) begin
         mx = mx >> 1;
         my = my >> 1;
         mz = mz >> 1;
      end
      eng_mag[0] = mx[EW-1:0];
      eng_mag[1] = my[EW-1:0];
      eng_mag[2] = mz[EW-1:0];

      ax = tgt_x_ff[POS_BITS-1] ? POS_BITS'(-tgt_x_ff) : POS_BITS'(tgt_x_ff);
      ay = tgt_y_ff[POS_BITS-1] ? POS_BITS'(-tgt_y_ff) : POS_BITS'(tgt_y_ff);
      centred = (CW'(ax) < CW'(center_tol_ff)) && (CW'(ay) < CW'(center_tol_ff)) &&
                ($signed(CW'(alt_ff)) < $signed(CW'(land_alt_ff)));
      fresh = AW'(age_ff) < AW'(fresh_ff);
      lost  = AW'(age_ff) > AW'(lost_ff);

      mode_in = mode_ff;
      if (mode_in == MODE_TRACKING && centred) mode_in = MODE_LANDING;
      if (mode_in == MODE_WAITING && fresh) mode_in = MODE_TRACKING;
      if (mode_in == MODE_TRACKING && lost) mode_in = MODE_LANDING;
   end

   always_comb begin
      state_in  = state_ff;
      eng_start = 1'b0;
      neg_in    = neg_ff;
      vx_in     = vx_ff;
      vy_in     = vy_ff;
      vz_in     = vz_ff;
      used_in   = used_ff;
      next_in   = next_ff;
      case (state_ff)
         T_IDLE: begin
            if (accept && req_type == REQ_CONTROL) begin
               used_in = mode_ff;
               next_in = mode_in;
               if (mode_ff == MODE_TRACKING) begin
                  eng_start = 1'b1;
                  neg_in    = {gz[GW-1], gy[GW-1], gx[GW-1]};
                  state_in  = T_CALC;
               end else if (mode_ff == MODE_LANDING) begin
                  vx_in    = '0;
                  vy_in    = '0;
                  vz_in    = -$signed({1'b0, max_speed_ff});
                  state_in = T_RESP;
               end
            end
         end
         T_CALC: begin
            if (eng_done) begin
               vx_in    = neg_ff[0] ? -$signed({1'b0, eng_q[0]}) : $signed({1'b0, eng_q[0]});
               vy_in    = neg_ff[1] ? -$signed({1'b0, eng_q[1]}) : $signed({1'b0, eng_q[1]});
               vz_in    = neg_ff[2] ? -$signed({1'b0, eng_q[2]}) : $signed({1'b0, eng_q[2]});
               state_in = T_RESP;
            end
         end
         T_RESP: begin
            if (rsp_ready) state_in = T_IDLE;
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= T_IDLE;
         mode_ff       <= MODE_WAITING;
         tgt_x_ff      <= '0;
         tgt_y_ff      <= '0;
         tgt_z_ff      <= '0;
         alt_ff        <= '0;
         age_ff        <= '1;
         max_speed_ff  <= SPEED_BITS'(1000);
         center_tol_ff <= SPEED_BITS'(100);
         land_alt_ff   <= CSR_BITS'(3000);
         hover_ff      <= SPEED_BITS'(2000);
         fresh_ff      <= SPEED_BITS'(40);
         lost_ff       <= SPEED_BITS'(50);
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_SPEED:    max_speed_ff  <= csr_wdata[SPEED_BITS-1:0];
               CSR_CENTER_TOL:   center_tol_ff <= csr_wdata[SPEED_BITS-1:0];
               CSR_LANDING_ALT:  land_alt_ff   <= csr_wdata;
               CSR_HOVER_OFFSET: hover_ff      <= csr_wdata[SPEED_BITS-1:0];
               CSR_FRESH_TICKS:  fresh_ff      <= csr_wdata[SPEED_BITS-1:0];
               CSR_LOST_TICKS:   lost_ff       <= csr_wdata[SPEED_BITS-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            case (req_type)
               REQ_CONTROL: mode_ff <= mode_in;
               REQ_TAG: begin
                  tgt_x_ff <= neg_sat(req_tag_x);
                  tgt_y_ff <= neg_sat(req_tag_y);
                  tgt_z_ff <= neg_sat(req_tag_z);
                  age_ff   <= '0;
               end
               REQ_ALTITUDE: alt_ff <= req_altitude;
               REQ_MODE: mode_ff <= req_mode_request ? MODE_LANDING : MODE_TRACKING;
               REQ_TICK: if (age_ff != '1) age_ff <= age_ff + 1'b1;
               default: ;
            endcase
         end
      end
      neg_ff  <= neg_in;
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      vz_ff   <= vz_in;
      used_ff <= used_in;
      next_ff <= next_in;
   end

   tlmg_engine #(
      .EW(EW)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (eng_start),
      .max_speed (max_speed_ff),
      .mag_in    (eng_mag),
      .done      (eng_done),
      .quo_out   (eng_q)
   );

   assign req_ready     = (state_ff == T_IDLE);
   assign rsp_valid     = (state_ff == T_RESP);
   assign rsp_vel_x     = vx_ff;
   assign rsp_vel_y     = vy_ff;
   assign rsp_vel_z     = vz_ff;
   assign rsp_mode_used = used_ff;
   assign rsp_mode_next = next_ff;

`ifndef NO_ASSERTIONS
   a_used_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mode_used == MODE_TRACKING) || (rsp_mode_used == MODE_LANDING))
      else $error("response from non-commanding mode");
   a_land_vertical: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode_used == MODE_LANDING |-> rsp_vel_x == '0 && rsp_vel_y == '0)
      else $error("landing command has horizontal velocity");
   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      eng_done |-> state_ff == T_CALC)
      else $error("engine finished outside calculation");
`endif

endmodule
`default_nettype wire
